// ----- design/ljfq_pkg.sv -----
// ----------------------------------------------------------------------------
// ljfq_pkg: shared types and constants of the longest-job-first scheduler
// Field widths, command and register codes, datapath operations, and the
// control/status structs that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package ljfq_pkg;

  // Field widths
  localparam int unsigned CMD_W    = 2;
  localparam int unsigned ID_W     = 6;
  localparam int unsigned KEY_W    = 16;
  localparam int unsigned SLICE_W  = 8;
  localparam int unsigned ID_SPACE = 64;

  // Default queue depth and matching count width
  localparam int unsigned MAX_TASKS_DEF = 64;
  localparam int unsigned CNT_W_DEF     = $clog2(MAX_TASKS_DEF + 1);

  // Configuration port
  localparam int unsigned APB_AW = 3;
  localparam int unsigned APB_DW = 32;

  localparam logic [SLICE_W-1:0] QUANTUM_RST = SLICE_W'(2);
  localparam logic               PREEMPT_RST = 1'b1;

  // Register index (paddr[2])
  localparam logic REG_QUANTUM = 1'b0;
  localparam logic REG_PREEMPT = 1'b1;

  typedef enum logic [CMD_W-1:0] {
    CMD_ENQUEUE = 2'd0,
    CMD_PICK    = 2'd1,
    CMD_TICK    = 2'd2,
    CMD_STEAL   = 2'd3
  } cmd_e;

  // Datapath operations issued by the controller
  typedef enum logic [3:0] {
    OP_NONE      = 4'd0,
    OP_LOAD      = 4'd1,
    OP_ENQ_BEGIN = 4'd2,
    OP_SHIFT     = 4'd3,
    OP_INS_AFTER = 4'd4,
    OP_INS_HEAD  = 4'd5,
    OP_POP_START = 4'd6,
    OP_POP       = 4'd7,
    OP_EMPTY     = 4'd8,
    OP_TICK      = 4'd9,
    OP_EMIT      = 4'd10
  } op_e;

  typedef struct packed {
    cmd_e             cmd;
    logic [ID_W-1:0]  task_id;
    logic [KEY_W-1:0] burst_left;
    logic             was_runnable;
    logic             idle_task;
    logic [KEY_W-1:0] current_burst_left;
  } item_t;

  typedef struct packed {
    logic [SLICE_W-1:0] quantum;
    logic               preemptive;
  } cfg_t;

  typedef struct packed {
    op_e op;
  } dp_cmd_t;

  typedef struct packed {
    cmd_e cmd;
    logic reject;
    logic empty;
    logic stop;
    logic idx_zero;
    logic out_free;
  } dp_status_t;

endpackage

// ----- design/ljfq_req_if.sv -----
// ----------------------------------------------------------------------------
// ljfq_req_if: scheduler request channel
// Valid/ready channel that carries one scheduler command and its operands.
// ----------------------------------------------------------------------------
interface ljfq_req_if
  import ljfq_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic [CMD_W-1:0]     cmd;
  logic [ID_W-1:0]      task_id;
  logic [KEY_W-1:0]     burst_left;
  logic                 was_runnable;
  logic                 idle_task;
  logic [KEY_W-1:0]     current_burst_left;

  modport source (
    output valid, cmd, task_id, burst_left, was_runnable, idle_task, current_burst_left,
    input  ready
  );

  modport sink (
    input  valid, cmd, task_id, burst_left, was_runnable, idle_task, current_burst_left,
    output ready
  );
endinterface

// ----- design/ljfq_rsp_if.sv -----
// ----------------------------------------------------------------------------
// ljfq_rsp_if: scheduler response channel
// Valid/ready channel that carries one result per scheduler command.
// ----------------------------------------------------------------------------
interface ljfq_rsp_if
  import ljfq_pkg::*;
#(
  parameter int unsigned CountW = CNT_W_DEF
);
  logic              valid;
  logic              ready;
  logic              task_found;
  logic [ID_W-1:0]   out_task_id;
  logic              resched;
  logic [CountW-1:0] queue_count;

  modport source (
    output valid, task_found, out_task_id, resched, queue_count,
    input  ready
  );

  modport sink (
    input  valid, task_found, out_task_id, resched, queue_count,
    output ready
  );
endinterface

// ----- design/ljfq_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// ljfq_cfg_regs: configuration registers
// APB-style write/read access to the time slice length and preemption enable.
// ----------------------------------------------------------------------------
module ljfq_cfg_regs
  import ljfq_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  logic [SLICE_W-1:0] quantum_q;
  logic               preempt_q;
  logic               wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // Write on the access phase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quantum_q <= QUANTUM_RST;
      preempt_q <= PREEMPT_RST;
    end else if (wr_en) begin
      unique case (paddr[2])
        REG_QUANTUM: quantum_q <= pwdata[SLICE_W-1:0];
        REG_PREEMPT: preempt_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Return the addressed register
  always_comb begin
    unique case (paddr[2])
      REG_QUANTUM: prdata = {{(APB_DW-SLICE_W){1'b0}}, quantum_q};
      REG_PREEMPT: prdata = {{(APB_DW-1){1'b0}}, preempt_q};
      default:     prdata = '0;
    endcase
  end

  assign cfg_o.quantum    = quantum_q;
  assign cfg_o.preemptive = preempt_q;

endmodule

// ----- design/ljfq_ctrl.sv -----
// ----------------------------------------------------------------------------
// ljfq_ctrl: scheduler controller
// One-hot state machine that sequences decode, sorted-insert walk, pop and
// result hand-off, issuing at most one datapath operation per cycle.
// ----------------------------------------------------------------------------
module ljfq_ctrl
  import ljfq_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_DECODE = 6'b000010,
    S_SCAN   = 6'b000100,
    S_INSERT = 6'b001000,
    S_POP    = 6'b010000,
    S_FINISH = 6'b100000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and datapath operation
  always_comb begin
    state_d    = state_q;
    cmd_o.op   = OP_NONE;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          state_d  = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (status_i.cmd)
          CMD_ENQUEUE: begin
            if (status_i.reject) begin
              state_d = S_FINISH;
            end else begin
              cmd_o.op = OP_ENQ_BEGIN;
              state_d  = status_i.empty ? S_INSERT : S_SCAN;
            end
          end
          CMD_PICK, CMD_STEAL: begin
            if (status_i.empty) begin
              cmd_o.op = OP_EMPTY;
              state_d  = S_FINISH;
            end else begin
              cmd_o.op = OP_POP_START;
              state_d  = S_POP;
            end
          end
          CMD_TICK: begin
            cmd_o.op = OP_TICK;
            state_d  = S_FINISH;
          end
          default: state_d = S_FINISH;
        endcase
      end
      S_SCAN: begin
        // Stop at the first entry that stays ahead, else shift it up
        if (status_i.stop) begin
          cmd_o.op = OP_INS_AFTER;
          state_d  = S_FINISH;
        end else begin
          cmd_o.op = OP_SHIFT;
          state_d  = status_i.idx_zero ? S_INSERT : S_SCAN;
        end
      end
      S_INSERT: begin
        cmd_o.op = OP_INS_HEAD;
        state_d  = S_FINISH;
      end
      S_POP: begin
        cmd_o.op = OP_POP;
        state_d  = S_FINISH;
      end
      S_FINISH: begin
        if (status_i.out_free) begin
          cmd_o.op = OP_EMIT;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

// ----- design/ljfq_datapath.sv -----
// ----------------------------------------------------------------------------
// ljfq_datapath: run queue storage and scheduler state
// Circular sorted queue in a one-write/one-read memory, task marks, current
// task and slice counter, result holding and output registers.
// ----------------------------------------------------------------------------
module ljfq_datapath
  import ljfq_pkg::*;
#(
  parameter int unsigned MAX_TASKS = MAX_TASKS_DEF,
  parameter int unsigned CntW      = $clog2(MAX_TASKS + 1)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  item_t           item_i,
  input  cfg_t            cfg_i,
  input  dp_cmd_t         cmd_i,
  output dp_status_t      status_o,
  input  logic            out_ready_i,
  output logic            out_valid_o,
  output logic            out_found_o,
  output logic [ID_W-1:0] out_id_o,
  output logic            out_resched_o,
  output logic [CntW-1:0] out_count_o
);

  localparam int unsigned AW    = $clog2(MAX_TASKS);
  localparam int unsigned ENT_W = KEY_W + ID_W;
  localparam logic [AW:0] DEPTH = (AW+1)'(MAX_TASKS);

  // Queue memory: {key, id}
  logic [ENT_W-1:0] mem [MAX_TASKS];
  logic [ENT_W-1:0] rd_data_q;

  logic [AW-1:0]       head_q;
  logic [CntW-1:0]     len_q;
  logic [ID_SPACE-1:0] queued_q;
  logic [ID_SPACE-1:0] front_q;
  logic                cur_valid_q;
  logic [ID_W-1:0]     cur_id_q;
  logic [SLICE_W-1:0]  slice_q;
  logic                out_valid_q;

  item_t           item_q;
  logic            front_hit_q;
  logic [AW-1:0]   idx_q;
  logic            res_found_q;
  logic [ID_W-1:0] res_id_q;
  logic            res_resched_q;
  logic            out_found_q;
  logic [ID_W-1:0] out_id_q;
  logic            out_resched_q;
  logic [CntW-1:0] out_count_q;

  logic               rd_en, wr_en;
  logic [AW-1:0]      rd_laddr, wr_laddr;
  logic [ENT_W-1:0]   wr_data;
  logic [AW-1:0]      tail_l;
  logic [CntW-1:0]    len_m1;
  logic [KEY_W-1:0]   rd_key;
  logic [ID_W-1:0]    rd_id;
  logic [SLICE_W-1:0] slice_dec;
  logic               preempt;
  logic               is_pick;
  logic               full;

  // Map a queue position to a memory address
  function automatic logic [AW-1:0] to_phys(input logic [AW-1:0] base,
                                            input logic [AW-1:0] pos);
    logic [AW:0] sum;
    sum = {1'b0, base} + {1'b0, pos};
    if (sum >= DEPTH) begin
      sum = sum - DEPTH;
    end
    return sum[AW-1:0];
  endfunction

  assign len_m1    = len_q - CntW'(1);
  assign tail_l    = len_m1[AW-1:0];
  assign rd_key    = rd_data_q[ENT_W-1:ID_W];
  assign rd_id     = rd_data_q[ID_W-1:0];
  assign slice_dec = (slice_q == '0) ? '0 : slice_q - SLICE_W'(1);
  assign is_pick   = (item_q.cmd == CMD_PICK);
  assign full      = (len_q == CntW'(MAX_TASKS));
  assign preempt   = !item_q.was_runnable && cfg_i.preemptive && cur_valid_q &&
                     (item_q.burst_left > item_q.current_burst_left);

  // Status to the controller
  assign status_o.cmd      = item_q.cmd;
  assign status_o.reject   = queued_q[item_q.task_id] || item_q.idle_task || full;
  assign status_o.empty    = (len_q == '0);
  assign status_o.stop     = front_hit_q ? (rd_key > item_q.burst_left)
                                         : (rd_key >= item_q.burst_left);
  assign status_o.idx_zero = (idx_q == '0);
  assign status_o.out_free = !out_valid_q || out_ready_i;

  // Memory port selection
  always_comb begin
    rd_en    = 1'b0;
    wr_en    = 1'b0;
    rd_laddr = tail_l;
    wr_laddr = idx_q + AW'(1);
    wr_data  = {item_q.burst_left, item_q.task_id};
    unique case (cmd_i.op)
      OP_ENQ_BEGIN: rd_en = 1'b1;
      OP_POP_START: begin
        rd_en    = 1'b1;
        rd_laddr = is_pick ? '0 : tail_l;
      end
      OP_SHIFT: begin
        rd_en    = 1'b1;
        rd_laddr = idx_q - AW'(1);
        wr_en    = 1'b1;
        wr_data  = rd_data_q;
      end
      OP_INS_AFTER: wr_en = 1'b1;
      OP_INS_HEAD: begin
        wr_en    = 1'b1;
        wr_laddr = '0;
      end
      default: ;
    endcase
  end

  // Queue memory with registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[to_phys(head_q, wr_laddr)] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= mem[to_phys(head_q, rd_laddr)];
    end
  end

  // Scheduler state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      len_q       <= '0;
      queued_q    <= '0;
      front_q     <= '0;
      cur_valid_q <= 1'b0;
      cur_id_q    <= '0;
      slice_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      unique case (cmd_i.op)
        OP_ENQ_BEGIN: front_q[item_q.task_id] <= 1'b0;
        OP_INS_AFTER, OP_INS_HEAD: begin
          len_q                    <= len_q + CntW'(1);
          queued_q[item_q.task_id] <= 1'b1;
          if (preempt) begin
            front_q[cur_id_q] <= 1'b1;
          end
        end
        OP_POP: begin
          len_q           <= len_m1;
          queued_q[rd_id] <= 1'b0;
          if (is_pick) begin
            head_q      <= to_phys(head_q, AW'(1));
            cur_valid_q <= 1'b1;
            cur_id_q    <= rd_id;
            slice_q     <= cfg_i.quantum;
          end
        end
        OP_EMPTY: begin
          if (is_pick) begin
            cur_valid_q <= 1'b0;
          end
        end
        OP_TICK: begin
          if (cur_valid_q) begin
            slice_q <= slice_dec;
          end
        end
        default: ;
      endcase
      // Hold the result until taken
      if (cmd_i.op == OP_EMIT) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Item, walk index and result payload
  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      OP_LOAD: begin
        item_q        <= item_i;
        res_found_q   <= 1'b0;
        res_id_q      <= '0;
        res_resched_q <= 1'b0;
      end
      OP_ENQ_BEGIN: begin
        front_hit_q <= front_q[item_q.task_id];
        idx_q       <= tail_l;
      end
      OP_SHIFT: idx_q <= idx_q - AW'(1);
      OP_INS_AFTER, OP_INS_HEAD: res_resched_q <= preempt;
      OP_POP: begin
        res_found_q <= 1'b1;
        res_id_q    <= rd_id;
      end
      OP_TICK: res_resched_q <= cur_valid_q && (slice_dec == '0);
      OP_EMIT: begin
        out_found_q   <= res_found_q;
        out_id_q      <= res_id_q;
        out_resched_q <= res_resched_q;
        out_count_q   <= len_q;
      end
      default: ;
    endcase
  end

  assign out_valid_o   = out_valid_q;
  assign out_found_o   = out_found_q;
  assign out_id_o      = out_id_q;
  assign out_resched_o = out_resched_q;
  assign out_count_o   = out_count_q;

endmodule

// ----- design/longest_job_first_quantum_scheduler_unit.sv -----
// ----------------------------------------------------------------------------
// longest_job_first_quantum_scheduler_unit: LJF run queue with time slice
//
// Commands arrive on req_i (valid/ready): enqueue, pick, tick, steal. Each
// transaction yields exactly one result on rsp_o: removed task (if any),
// reschedule request and queue length afterwards. The queue is kept sorted
// by remaining burst, largest first, in a circular buffer memory.
// The user must write quantum and preemption enable over the APB port only
// while idle; the block itself does not enforce it. One command is processed
// at a time. The insert walk moves one entry per cycle through the single
// write port of the queue memory. A new command is accepted in the cycle
// after the previous result is loaded, even while that result still waits
// on rsp_o. If the receiver stalls, the finished result waits in the output
// register and the next command stalls only at its own hand-off.
// Reset empties the queue, clears all task marks, makes the idle task
// current, and loads quantum 2 and preemption on. No clearing pass needed.
// ----------------------------------------------------------------------------
module longest_job_first_quantum_scheduler_unit
  import ljfq_pkg::*;
#(
  parameter int unsigned MAX_TASKS = MAX_TASKS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  ljfq_req_if.sink          req_i,
  ljfq_rsp_if.source        rsp_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  localparam int unsigned CntW = $clog2(MAX_TASKS + 1);

  cfg_t       cfg;
  item_t      item;
  dp_cmd_t    dp_cmd;
  dp_status_t dp_status;

  // Pack the request payload
  assign item.cmd                = cmd_e'(req_i.cmd);
  assign item.task_id            = req_i.task_id;
  assign item.burst_left         = req_i.burst_left;
  assign item.was_runnable       = req_i.was_runnable;
  assign item.idle_task          = req_i.idle_task;
  assign item.current_burst_left = req_i.current_burst_left;

  ljfq_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  ljfq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (req_i.ready),
    .status_i   (dp_status),
    .cmd_o      (dp_cmd)
  );

  ljfq_datapath #(
    .MAX_TASKS (MAX_TASKS),
    .CntW      (CntW)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .item_i        (item),
    .cfg_i         (cfg),
    .cmd_i         (dp_cmd),
    .status_o      (dp_status),
    .out_ready_i   (rsp_o.ready),
    .out_valid_o   (rsp_o.valid),
    .out_found_o   (rsp_o.task_found),
    .out_id_o      (rsp_o.out_task_id),
    .out_resched_o (rsp_o.resched),
    .out_count_o   (rsp_o.queue_count)
  );

endmodule

// ----- design/ljfq_checker.sv -----
// ----------------------------------------------------------------------------
// ljfq_checker: port-level checks for the scheduler
// Watches the request, response and handshake ports of the top level.
// ----------------------------------------------------------------------------
module ljfq_checker
  import ljfq_pkg::*;
#(
  parameter int unsigned MAX_TASKS = MAX_TASKS_DEF,
  parameter int unsigned CntW      = $clog2(MAX_TASKS + 1)
) (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            req_valid_i,
  input logic            req_ready_i,
  input logic            rsp_valid_i,
  input logic            rsp_ready_i,
  input logic            rsp_found_i,
  input logic [ID_W-1:0] rsp_id_i,
  input logic            rsp_resched_i,
  input logic [CntW-1:0] rsp_count_i
);

  // Queue length never exceeds its depth
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> (rsp_count_i <= CntW'(MAX_TASKS)))
    else $error("queue_count above depth");

  // Only one command is in flight
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("request accepted while busy");

  // A removal never requests a reschedule
  a_pop_no_resched: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_found_i |-> !rsp_resched_i)
    else $error("resched on pick or steal");

  // No task id without a removal
  a_id_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_found_i |-> (rsp_id_i == '0))
    else $error("task id without removal");

  // Stalled result holds
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_count_i))
    else $error("stalled result changed");

endmodule

bind longest_job_first_quantum_scheduler_unit ljfq_checker #(
  .MAX_TASKS (MAX_TASKS)
) u_ljfq_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .req_valid_i   (req_i.valid),
  .req_ready_i   (req_i.ready),
  .rsp_valid_i   (rsp_o.valid),
  .rsp_ready_i   (rsp_o.ready),
  .rsp_found_i   (rsp_o.task_found),
  .rsp_id_i      (rsp_o.out_task_id),
  .rsp_resched_i (rsp_o.resched),
  .rsp_count_i   (rsp_o.queue_count)
);

// ----- verif/tb_longest_job_first_quantum_scheduler_unit.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_longest_job_first_quantum_scheduler_unit: self-checking scheduler bench
// Drives enqueue, pick, tick and steal commands into the scheduler with bursty
// request traffic and a stalling response side. A scoreboard class keeps its
// own copy of the sorted run queue, the task marks, the current task and its
// slice, predicts one outcome per accepted command, and compares every
// returned result field by field. Quantum and preemption are reprogrammed
// over APB between phases while the scheduler is idle.
// ----------------------------------------------------------------------------
module tb_longest_job_first_quantum_scheduler_unit;
  import ljfq_pkg::*;

  localparam int unsigned CLK_PERIOD   = 12;
  localparam int unsigned LIMIT_CYCLES = 1_000_000;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned PHASE_ITEMS  = 200;
  localparam int unsigned NUM_PHASES   = 8;
  localparam int unsigned MAX_REPORTS  = 40;
  localparam int unsigned RANDOM_Q     = 999;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [ID_W-1:0]  id;
  } slot_t;

  typedef struct packed {
    logic                 found;
    logic [ID_W-1:0]      id;
    logic                 resched;
    logic [CNT_W_DEF-1:0] count;
  } outcome_t;

  // --------------------------------------------------------------------------
  // Scoreboard: run queue prediction and result checking
  // --------------------------------------------------------------------------
  class run_queue_scoreboard;
    slot_t              runq[$];
    bit                 queued[ID_SPACE];
    bit                 front_marked[ID_SPACE];
    bit                 cur_valid;
    logic [ID_W-1:0]    cur_id;
    logic [SLICE_W-1:0] slice_left;
    logic [SLICE_W-1:0] quantum;
    bit                 preemptive;
    outcome_t           expected_outcomes[$];
    int unsigned        errors;

    function new();
      cur_valid  = 1'b0;
      cur_id     = '0;
      slice_left = '0;
      quantum    = QUANTUM_RST;
      preemptive = PREEMPT_RST;
      errors     = 0;
    endfunction

    function void set_register(logic idx, logic [APB_DW-1:0] value);
      if (idx == REG_QUANTUM) begin
        quantum = value[SLICE_W-1:0];
      end else begin
        preemptive = value[0];
      end
    endfunction

    function int unsigned pending();
      return expected_outcomes.size();
    endfunction

    task report(string msg);
      if (errors < MAX_REPORTS) $display("mismatch at %0t: %s", $time, msg);
      errors++;
    endtask

    // Advance the run queue by one accepted command and queue its outcome
    function void note_command(item_t c);
      outcome_t    o;
      slot_t       s;
      int unsigned pos;
      bit          front;
      o = '0;
      case (c.cmd)
        CMD_ENQUEUE: begin
          // Drop idle, already queued, or overflow enqueues
          if (!queued[c.task_id] && !c.idle_task && runq.size() < MAX_TASKS_DEF) begin
            front = front_marked[c.task_id];
            front_marked[c.task_id] = 1'b0;
            pos = 0;
            while (pos < runq.size() &&
                   (front ? runq[pos].key > c.burst_left : runq[pos].key >= c.burst_left))
              pos++;
            s.key = c.burst_left;
            s.id  = c.task_id;
            runq.insert(pos, s);
            queued[c.task_id] = 1'b1;
            // Preempt a running task with a shorter burst
            if (!c.was_runnable && preemptive && cur_valid &&
                c.burst_left > c.current_burst_left) begin
              front_marked[cur_id] = 1'b1;
              o.resched = 1'b1;
            end
          end
        end
        CMD_PICK: begin
          if (runq.size() > 0) begin
            s = runq.pop_front();
            queued[s.id] = 1'b0;
            o.found = 1'b1;
            o.id = s.id;
            cur_valid = 1'b1;
            cur_id = s.id;
            slice_left = quantum;
          end else begin
            cur_valid = 1'b0;
          end
        end
        CMD_TICK: begin
          // Charge the slice, saturating at zero
          if (cur_valid) begin
            if (slice_left != 0) slice_left--;
            if (slice_left == 0) o.resched = 1'b1;
          end
        end
        CMD_STEAL: begin
          if (runq.size() > 0) begin
            s = runq.pop_back();
            queued[s.id] = 1'b0;
            o.found = 1'b1;
            o.id = s.id;
          end
        end
      endcase
      o.count = CNT_W_DEF'(runq.size());
      expected_outcomes.push_back(o);
    endfunction

    // Compare one returned result with the oldest outcome
    task check_result(outcome_t got);
      outcome_t want;
      if (expected_outcomes.size() == 0) begin
        report("result transaction with no command outstanding");
      end else begin
        want = expected_outcomes.pop_front();
        if (got.found !== want.found)
          report($sformatf("task_found %0b, want %0b", got.found, want.found));
        if (got.id !== want.id)
          report($sformatf("out_task_id %0d, want %0d", got.id, want.id));
        if (got.resched !== want.resched)
          report($sformatf("resched %0b, want %0b", got.resched, want.resched));
        if (got.count !== want.count)
          report($sformatf("queue_count %0d, want %0d", got.count, want.count));
      end
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, buses and the block
  // --------------------------------------------------------------------------
  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  bit          hold_rsp = 1'b0;
  int unsigned burst_n = 1;

  run_queue_scoreboard sb = new();

  ljfq_req_if req_bus ();
  ljfq_rsp_if rsp_bus ();

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  longest_job_first_quantum_scheduler_unit DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_bus),
    .rsp_o   (rsp_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic logic [KEY_W-1:0] pick_key();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2, 3, 4: return KEY_W'($urandom_range(0, 7));
      default: return KEY_W'($urandom);
    endcase
  endfunction

  // Build a non-enqueue command with noise in the unused fields
  function automatic item_t ctl(cmd_e cmd);
    item_t c;
    c.cmd = cmd;
    c.task_id = ID_W'($urandom);
    c.burst_left = KEY_W'($urandom);
    c.was_runnable = 1'($urandom_range(0, 1));
    c.idle_task = 1'($urandom_range(0, 1));
    c.current_burst_left = KEY_W'($urandom);
    return c;
  endfunction

  function automatic item_t enq(logic [ID_W-1:0] id, logic [KEY_W-1:0] key,
                                logic runnable, logic idle, logic [KEY_W-1:0] cur_key);
    item_t c;
    c.cmd = CMD_ENQUEUE;
    c.task_id = id;
    c.burst_left = key;
    c.was_runnable = runnable;
    c.idle_task = idle;
    c.current_burst_left = cur_key;
    return c;
  endfunction

  // Draw a random command; enqueues favor free ids and the running task
  function automatic item_t make_command(int unsigned enq_pct, int unsigned pick_pct,
                                         int unsigned tick_pct);
    item_t       c;
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < enq_pct) begin
      c = ctl(CMD_ENQUEUE);
      roll = $urandom_range(0, 99);
      if (roll < 20 && sb.cur_valid) begin
        c.task_id = sb.cur_id;
      end else if (roll < 85) begin
        for (int t = 0; t < 8 && sb.queued[c.task_id]; t++) c.task_id = ID_W'($urandom);
      end
      c.burst_left = pick_key();
      c.current_burst_left = pick_key();
      c.idle_task = ($urandom_range(0, 99) < 8);
    end else if (roll < enq_pct + pick_pct) begin
      c = ctl(CMD_PICK);
    end else if (roll < enq_pct + pick_pct + tick_pct) begin
      c = ctl(CMD_TICK);
    end else begin
      c = ctl(CMD_STEAL);
    end
    return c;
  endfunction

  // Offer one command, hold it until accepted, then maybe open a gap
  task automatic send_item(input item_t c);
    req_bus.valid = 1'b1;
    req_bus.cmd = c.cmd;
    req_bus.task_id = c.task_id;
    req_bus.burst_left = c.burst_left;
    req_bus.was_runnable = c.was_runnable;
    req_bus.idle_task = c.idle_task;
    req_bus.current_burst_left = c.current_burst_left;
    do @(posedge clk_i); while (!req_bus.ready);
    @(negedge clk_i);
    if (burst_n != 0) burst_n--;
    if (burst_n == 0) begin
      req_bus.valid = 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk_i);
      burst_n = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
    end
  endtask

  // Stop offering and wait for every outstanding result
  task automatic drain_results();
    req_bus.valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
  endtask

  // APB write: setup cycle, then access cycle until pready
  task automatic write_reg(input logic idx, input logic [APB_DW-1:0] value);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 2'b00};
    pwdata = value;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    sb.set_register(idx, value);
  endtask

  // --------------------------------------------------------------------------
  // Observe accepted transactions on both channels
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : observe
    item_t    seen;
    outcome_t got;
    if (rst_ni) begin
      if (req_bus.valid && req_bus.ready) begin
        seen.cmd = cmd_e'(req_bus.cmd);
        seen.task_id = req_bus.task_id;
        seen.burst_left = req_bus.burst_left;
        seen.was_runnable = req_bus.was_runnable;
        seen.idle_task = req_bus.idle_task;
        seen.current_burst_left = req_bus.current_burst_left;
        sb.note_command(seen);
      end
      if (rsp_bus.valid && rsp_bus.ready) begin
        got.found = rsp_bus.task_found;
        got.id = rsp_bus.out_task_id;
        got.resched = rsp_bus.resched;
        got.count = rsp_bus.queue_count;
        sb.check_result(got);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Response side: windows of full rate, random stalls and toggling,
  // plus a long hold-off on request
  // --------------------------------------------------------------------------
  initial begin : rsp_pacing
    int unsigned window;
    int unsigned mode;
    window = 0;
    mode = 0;
    rsp_bus.ready = 1'b0;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_rsp) begin
        for (int n = 0; n < HOLD_CYCLES; n++) begin
          rsp_bus.ready = 1'b0;
          @(negedge clk_i);
        end
        hold_rsp = 1'b0;
      end
      if (window == 0) begin
        window = $urandom_range(16, 96);
        mode = $urandom_range(0, 2);
      end
      window--;
      case (mode)
        0: rsp_bus.ready = 1'b1;
        1: rsp_bus.ready = ($urandom_range(0, 3) != 0);
        default: rsp_bus.ready = window[2];
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned ph_quantum [NUM_PHASES] = '{255, 1, 0, 2, 5, 128, RANDOM_Q, 3};
    bit          ph_preempt [NUM_PHASES] = '{1, 0, 1, 1, 1, 0, 1, 1};
    int unsigned ph_enq     [NUM_PHASES] = '{70, 40, 35, 40, 70, 15, 35, 40};
    int unsigned ph_pick    [NUM_PHASES] = '{10, 25, 20, 25, 10, 40, 20, 25};
    int unsigned ph_tick    [NUM_PHASES] = '{10, 25, 40, 25, 10, 15, 40, 25};
    bit          ph_hold    [NUM_PHASES] = '{1, 0, 0, 0, 1, 0, 0, 0};
    logic [APB_DW-1:0] q;
    logic              pre;

    req_bus.valid = 1'b0;
    req_bus.cmd = CMD_ENQUEUE;
    req_bus.task_id = '0;
    req_bus.burst_left = '0;
    req_bus.was_runnable = 1'b0;
    req_bus.idle_task = 1'b0;
    req_bus.current_burst_left = '0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed corners under reset configuration
    send_item(ctl(CMD_TICK));                              // tick while idle runs
    send_item(ctl(CMD_PICK));                              // pick on empty queue
    send_item(ctl(CMD_STEAL));                             // steal on empty queue
    send_item(enq(6'd5, 16'h1234, 1'b0, 1'b1, 16'h0));     // idle task is ignored
    send_item(enq(6'd0, 16'hFFFF, 1'b0, 1'b0, 16'h0));     // no preemption while idle
    send_item(enq(6'd63, 16'h0000, 1'b0, 1'b0, 16'h0));
    send_item(enq(6'd10, 16'h8000, 1'b1, 1'b0, 16'hFFFF));
    send_item(enq(6'd10, 16'h0001, 1'b0, 1'b0, 16'h0));    // already queued
    send_item(enq(6'd11, 16'h8000, 1'b1, 1'b0, 16'h0));    // equal key goes after
    send_item(ctl(CMD_PICK));
    send_item(ctl(CMD_TICK));
    send_item(ctl(CMD_TICK));                              // slice runs out
    send_item(ctl(CMD_TICK));                              // slice saturates at zero
    send_item(enq(6'd20, 16'h9000, 1'b0, 1'b0, 16'h1000)); // preempt, front-mark current
    send_item(enq(6'd21, 16'h9000, 1'b1, 1'b0, 16'h0));    // runnable: no preemption
    send_item(enq(6'd0, 16'h9000, 1'b0, 1'b0, 16'hFFFF));  // front-marked goes first
    send_item(enq(6'd22, 16'hFFFF, 1'b0, 1'b0, 16'hFFFF)); // equal to current key
    send_item(ctl(CMD_STEAL));
    send_item(ctl(CMD_PICK));
    send_item(ctl(CMD_PICK));
    drain_results();

    // Random phases, each under its own configuration
    for (int p = 0; p < NUM_PHASES; p++) begin
      q = (ph_quantum[p] == RANDOM_Q) ? $urandom_range(1, 255) : ph_quantum[p];
      pre = (ph_quantum[p] == RANDOM_Q) ? 1'($urandom_range(0, 1)) : ph_preempt[p];
      write_reg(REG_QUANTUM, q);
      write_reg(REG_PREEMPT, {{(APB_DW-1){1'b0}}, pre});
      if (ph_hold[p]) hold_rsp = 1'b1;
      repeat (PHASE_ITEMS) send_item(make_command(ph_enq[p], ph_pick[p], ph_tick[p]));
      drain_results();
    end

    // Catch any stray results before the verdict
    repeat (MAX_TASKS_DEF + 8) @(negedge clk_i);
    if (sb.errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Bound the run
  initial begin : watchdog
    #(LIMIT_CYCLES * CLK_PERIOD);
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// ----- files.f -----
design/ljfq_pkg.sv
design/ljfq_req_if.sv
design/ljfq_rsp_if.sv
design/ljfq_cfg_regs.sv
design/ljfq_ctrl.sv
design/ljfq_datapath.sv
design/longest_job_first_quantum_scheduler_unit.sv
design/ljfq_checker.sv
verif/tb_longest_job_first_quantum_scheduler_unit.sv
